/* rtl/gbpf_pkg.sv */
// gbpf_pkg: shared types and constants for the gapped byte pair finder
// used by every module under rtl except gbpf_ram; depends on nothing
package gbpf_pkg;

  localparam int DIST_W     = 6;
  localparam int BYTE_W     = 8;
  localparam int OFFS_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int MAX_DISTANCE_DEF = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BYTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BYTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE    = 2'd2;

  typedef struct packed {
    logic [OFFS_W-1:0] offset;
    logic [BYTE_W-1:0] old_byte;
    logic [BYTE_W-1:0] new_byte;
    logic [DIST_W-1:0] start;
    logic [DIST_W-1:0] gap;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [DIST_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ring_wr_t;

  typedef struct packed {
    logic              busy;
    logic [DIST_W-1:0] addr;
  } ring_rd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HEAD,
    BK_BODY,
    BK_TAIL
  } bk_state_t;

endpackage

/* rtl/gapped_byte_pair_finder.sv */
// gapped_byte_pair_finder: top level, ties front, match queue, back and the delay ring
// depends on gbpf_pkg, gbpf_ram, gbpf_front, gbpf_jobq and gbpf_back
//
//  channel  ports                                        handshake
//  input    in_data_byte                                 in_valid / in_stall
//  output   out_match_offset, out_window_byte,           out_valid / out_stall
//           out_last_of_run
//  config   cfg_index, cfg_wdata                         cfg_we, no wait
//
// one byte per cycle while no pair is found; the ring read port and compare set this
// a found pair stalls input while the back side walks
// the window through the same ring read port, one result per cycle when out_stall is low
// synchronous active-low reset clears control and config; the ring holds no reset
// output stalls only hold the back side; the front keeps pace until a pair is found
module gapped_byte_pair_finder #(
  parameter int MAX_DISTANCE = gbpf_pkg::MAX_DISTANCE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gbpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbpf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gbpf_pkg::BYTE_W-1:0]       in_data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gbpf_pkg::OFFS_W-1:0]       out_match_offset,
  output logic [gbpf_pkg::BYTE_W-1:0]       out_window_byte,
  output logic                              out_last_of_run
);
  import gbpf_pkg::*;

  localparam int AW = (MAX_DISTANCE > 1) ? $clog2(MAX_DISTANCE) : 1;

  ring_wr_t          ring_wr;
  ring_rd_t          back_rd;
  logic [DIST_W-1:0] front_raddr;
  logic [DIST_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;
  logic              push;
  job_t              push_job;
  logic              q_valid;
  job_t              q_job;
  logic              pop;
  logic              hold;

  assign hold  = q_valid || back_rd.busy;
  assign raddr = back_rd.busy ? back_rd.addr : front_raddr;

  gbpf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_DISTANCE),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_wr.we),
    .waddr (ring_wr.addr[AW-1:0]),
    .wdata (ring_wr.data),
    .raddr (raddr[AW-1:0]),
    .rdata (rdata)
  );

  gbpf_front #(
    .MAX_DISTANCE (MAX_DISTANCE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .hold_i       (hold),
    .raddr_o      (front_raddr),
    .rdata_i      (rdata),
    .wr_o         (ring_wr),
    .push_o       (push),
    .job_o        (push_job)
  );

  gbpf_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  gbpf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid_i        (q_valid),
    .q_job_i          (q_job),
    .pop_o            (pop),
    .rd_o             (back_rd),
    .rdata_i          (rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match_offset (out_match_offset),
    .out_window_byte  (out_window_byte),
    .out_last_of_run  (out_last_of_run)
  );

  // the ring must not change under a window walk
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    back_rd.busy |-> !ring_wr.we)
    else $error("ring written while window is read");

  a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
    back_rd.busy |-> in_stall)
    else $error("byte taken while window is read");

endmodule

/* rtl/gbpf_ram.sv */
// gbpf_ram: generic single write port, single read port ram with registered read
// read returns the old contents on a same-address write; no package dependency
module gbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/gbpf_front.sv */
// gbpf_front: config registers, byte intake, ring write and pair classification
// depends on gbpf_pkg; reads the ring through the shared read port in the top level
module gbpf_front #(
  parameter int MAX_DISTANCE = gbpf_pkg::MAX_DISTANCE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gbpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbpf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gbpf_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                                hold_i,
  output logic [gbpf_pkg::DIST_W-1:0]         raddr_o,
  input  logic [gbpf_pkg::BYTE_W-1:0]         rdata_i,
  output gbpf_pkg::ring_wr_t                  wr_o,
  output logic                                push_o,
  output gbpf_pkg::job_t                      job_o
);
  import gbpf_pkg::*;

  localparam logic [DIST_W-1:0] MAX_D = DIST_W'(MAX_DISTANCE);

  logic [BYTE_W-1:0] first_r, second_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] ptr_r, ptr_nxt;
  logic [DIST_W-1:0] fill_r, fill_nxt;
  logic [OFFS_W-1:0] count_r, count_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_fill_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [DIST_W-1:0] s1_ptr_r;
  logic [DIST_W-1:0] s1_next_r;
  logic [OFFS_W-1:0] s1_offset_r;
  logic              byp_r;
  logic [BYTE_W-1:0] byp_data_r;

  logic [DIST_W-1:0] eff_d;
  logic [DIST_W-1:0] ptr_use;
  logic [DIST_W-1:0] ptr_adv;
  logic              accept;
  logic              is_fill;
  logic [BYTE_W-1:0] old_byte;
  logic              s1_hit;

  always_comb begin
    if (dist_r == '0) begin
      eff_d = DIST_W'(1);
    end else if (dist_r > MAX_D) begin
      eff_d = MAX_D;
    end else begin
      eff_d = dist_r;
    end
  end

  assign ptr_use  = (ptr_r >= eff_d) ? '0 : ptr_r;
  assign ptr_adv  = (ptr_use + DIST_W'(1) >= eff_d) ? '0 : ptr_use + DIST_W'(1);
  assign is_fill  = (fill_r < eff_d);
  assign old_byte = byp_r ? byp_data_r : rdata_i;
  assign s1_hit   = s1_valid_r && !s1_fill_r && (old_byte == first_r)
                    && (s1_byte_r == second_r);
  assign in_stall = hold_i || s1_hit;
  assign accept   = in_valid && !in_stall;
  assign raddr_o  = ptr_use;

  always_comb begin
    ptr_nxt      = ptr_r;
    fill_nxt     = fill_r;
    count_nxt    = count_r;
    s1_valid_nxt = accept;
    if (cfg_we && cfg_index == CFG_DISTANCE) begin
      ptr_nxt  = '0;
      fill_nxt = '0;
    end else if (accept) begin
      ptr_nxt   = ptr_adv;
      count_nxt = count_r + OFFS_W'(1);
      if (is_fill) begin
        fill_nxt = fill_r + DIST_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r    <= '0;
      second_r   <= '0;
      dist_r     <= DIST_W'(1);
      ptr_r      <= '0;
      fill_r     <= '0;
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_FIRST_BYTE) begin
        first_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_SECOND_BYTE) begin
        second_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_DISTANCE) begin
        dist_r <= cfg_wdata[DIST_W-1:0];
      end
      ptr_r      <= ptr_nxt;
      fill_r     <= fill_nxt;
      count_r    <= count_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fill_r   <= is_fill;
      s1_byte_r   <= in_data_byte;
      s1_ptr_r    <= ptr_use;
      s1_next_r   <= ptr_adv;
      s1_offset_r <= count_r - OFFS_W'(eff_d);
      byp_r       <= s1_valid_r && (s1_ptr_r == ptr_use);
      byp_data_r  <= s1_byte_r;
    end
  end

  assign wr_o.we   = s1_valid_r;
  assign wr_o.addr = s1_ptr_r;
  assign wr_o.data = s1_byte_r;

  assign push_o          = s1_hit;
  assign job_o.offset    = s1_offset_r;
  assign job_o.old_byte  = old_byte;
  assign job_o.new_byte  = s1_byte_r;
  assign job_o.start     = s1_next_r;
  assign job_o.gap       = eff_d;

  // back side busy means the pending byte has already resolved
  a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    hold_i |-> !s1_valid_r)
    else $error("front stage occupied while back side busy");

  // fill phase never exceeds the distance
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_fill_r |-> fill_r <= eff_d)
    else $error("fill count beyond distance");

endmodule

/* rtl/gbpf_jobq.sv */
// gbpf_jobq: one-entry match queue between front and back
// depends on gbpf_pkg for the match descriptor type
module gbpf_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  gbpf_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           valid_o,
  output gbpf_pkg::job_t job_o
);
  import gbpf_pkg::*;

  logic valid_r, valid_nxt;
  job_t job_r;

  always_comb begin
    valid_nxt = valid_r;
    if (pop_i) begin
      valid_nxt = 1'b0;
    end
    if (push_i) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      job_r <= job_i;
    end
  end

  assign valid_o = valid_r;
  assign job_o   = job_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !valid_r || pop_i)
    else $error("match queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> valid_r)
    else $error("match queue underflow");

endmodule

/* rtl/gbpf_back.sv */
// gbpf_back: walks a matched window out of the ring, oldest byte first
// depends on gbpf_pkg; owns the ring read port while busy
module gbpf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid_i,
  input  gbpf_pkg::job_t                q_job_i,
  output logic                          pop_o,
  output gbpf_pkg::ring_rd_t            rd_o,
  input  logic [gbpf_pkg::BYTE_W-1:0]   rdata_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gbpf_pkg::OFFS_W-1:0]   out_match_offset,
  output logic [gbpf_pkg::BYTE_W-1:0]   out_window_byte,
  output logic                          out_last_of_run
);
  import gbpf_pkg::*;

  bk_state_t         state_r, state_nxt;
  job_t              job_r;
  logic [DIST_W-1:0] addr_r, addr_nxt;
  logic [DIST_W-1:0] cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt;
  logic [OFFS_W-1:0] ooffs_r;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;
  logic              load;
  logic              out_free;
  logic [DIST_W-1:0] addr_inc;

  assign out_free = !ov_r || !out_stall;
  assign addr_inc = (addr_r + DIST_W'(1) >= job_r.gap) ? '0 : addr_r + DIST_W'(1);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    cnt_nxt   = cnt_r;
    pop_o     = 1'b0;
    load      = 1'b0;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o     = 1'b1;
          addr_nxt  = q_job_i.start;
          state_nxt = BK_HEAD;
        end
      end
      BK_HEAD: begin
        if (out_free) begin
          load      = 1'b1;
          obyte_nxt = job_r.old_byte;
          olast_nxt = 1'b0;
          cnt_nxt   = job_r.gap - DIST_W'(1);
          state_nxt = (job_r.gap == DIST_W'(1)) ? BK_TAIL : BK_BODY;
        end
      end
      BK_BODY: begin
        if (out_free) begin
          load      = 1'b1;
          obyte_nxt = rdata_i;
          olast_nxt = 1'b0;
          addr_nxt  = addr_inc;
          cnt_nxt   = cnt_r - DIST_W'(1);
          if (cnt_r == DIST_W'(1)) begin
            state_nxt = BK_TAIL;
          end
        end
      end
      BK_TAIL: begin
        if (out_free) begin
          load      = 1'b1;
          obyte_nxt = job_r.new_byte;
          olast_nxt = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    ov_nxt = load ? 1'b1 : (out_stall ? ov_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
    if (pop_o) begin
      job_r <= q_job_i;
    end
    if (load) begin
      ooffs_r <= job_r.offset;
      obyte_r <= obyte_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign rd_o.busy = (state_r != BK_IDLE) || q_valid_i;
  assign rd_o.addr = addr_nxt;

  assign out_valid        = ov_r;
  assign out_match_offset = ooffs_r;
  assign out_window_byte  = obyte_r;
  assign out_last_of_run  = olast_r;

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_BODY |-> cnt_r != '0)
    else $error("window walk with no bytes left");

  a_tail_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_TAIL && out_free |=> out_valid && out_last_of_run)
    else $error("run did not end with a flagged result");

endmodule

/* tb/gapped_byte_pair_finder_chk.sv */
// gapped_byte_pair_finder_chk: watches the config port and both channels, predicts
// the window runs of the gapped byte pair finder and compares every output transfer
// depends on gbpf_pkg
module gapped_byte_pair_finder_chk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [gbpf_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [gbpf_pkg::OFFS_W-1:0]     out_match_offset,
  input  logic [gbpf_pkg::BYTE_W-1:0]     out_window_byte,
  input  logic                            out_last_of_run,
  output int                              mismatches,
  output int                              pending_results,
  output int                              results_checked
);
  import gbpf_pkg::*;

  typedef struct {
    logic [OFFS_W-1:0] offset;
    logic [BYTE_W-1:0] wbyte;
    logic              is_last;
  } window_rec_t;

  window_rec_t       window_q[$];
  logic [BYTE_W-1:0] first_val;
  logic [BYTE_W-1:0] second_val;
  logic [DIST_W-1:0] pair_gap;
  logic [BYTE_W-1:0] history [0:MAX_DISTANCE_DEF-1];
  logic [DIST_W-1:0] ring_ptr;
  logic [DIST_W-1:0] fill_cnt;
  logic [OFFS_W-1:0] stream_pos;
  int                err_cnt;
  int                seen_cnt;

  task automatic scan_byte(input logic [BYTE_W-1:0] b);
    int unsigned       d;
    int unsigned       p;
    int unsigned       n;
    logic [BYTE_W-1:0] old;
    logic [OFFS_W-1:0] offs;
    window_rec_t       rec;
    d = (pair_gap == 0) ? 1 : 32'(pair_gap);
    if (d > MAX_DISTANCE_DEF) d = MAX_DISTANCE_DEF;
    p = 32'(ring_ptr);
    if (p >= d) p = 0;
    offs = stream_pos - d;
    stream_pos = stream_pos + 1;
    if (fill_cnt < d) begin
      history[p] = b;
      ring_ptr = DIST_W'((p + 1 >= d) ? 0 : p + 1);
      fill_cnt = fill_cnt + DIST_W'(1);
      return;
    end
    old = history[p];
    history[p] = b;
    p = (p + 1 >= d) ? 0 : p + 1;
    ring_ptr = DIST_W'(p);
    if (old == first_val && b == second_val) begin
      rec.offset = offs;
      rec.wbyte = old;
      rec.is_last = 1'b0;
      window_q.push_back(rec);
      for (int k = 0; k < d; k++) begin
        n = p + k;
        if (n >= d) n = n - d;
        rec.wbyte = history[n];
        rec.is_last = (k + 1 == d);
        window_q.push_back(rec);
      end
    end
  endtask

  task automatic check_result();
    window_rec_t want;
    if (window_q.size() == 0) begin
      err_cnt++;
      $display("%0t: unexpected result offset=%h byte=%h last=%b", $time,
               out_match_offset, out_window_byte, out_last_of_run);
      return;
    end
    want = window_q.pop_front();
    seen_cnt++;
    if (out_match_offset !== want.offset) begin
      err_cnt++;
      $display("%0t: match_offset expected %h got %h", $time, want.offset, out_match_offset);
    end
    if (out_window_byte !== want.wbyte) begin
      err_cnt++;
      $display("%0t: window_byte expected %h got %h", $time, want.wbyte, out_window_byte);
    end
    if (out_last_of_run !== want.is_last) begin
      err_cnt++;
      $display("%0t: last_of_run expected %b got %b", $time, want.is_last, out_last_of_run);
    end
  endtask

  initial begin
    err_cnt = 0;
    seen_cnt = 0;
    mismatches = 0;
    pending_results = 0;
    results_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      first_val = '0;
      second_val = '0;
      pair_gap = 6'd1;
      ring_ptr = '0;
      fill_cnt = '0;
      stream_pos = '0;
      window_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_BYTE: first_val = cfg_wdata[BYTE_W-1:0];
          CFG_SECOND_BYTE: second_val = cfg_wdata[BYTE_W-1:0];
          CFG_DISTANCE: begin
            pair_gap = cfg_wdata[DIST_W-1:0];
            ring_ptr = '0;
            fill_cnt = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) scan_byte(in_data_byte);
      if (out_valid && !out_stall) check_result();
    end
    mismatches <= err_cnt;
    pending_results <= window_q.size();
    results_checked <= seen_cnt;
  end

endmodule

/* tb/gapped_byte_pair_finder_tb.sv */
// gapped_byte_pair_finder_tb: stimulus and verdict for the gapped byte pair finder
// directed pairs, then random phases with planted pairs; checking sits in the checker
// depends on gbpf_pkg, gapped_byte_pair_finder and gapped_byte_pair_finder_chk
module gapped_byte_pair_finder_tb;
  import gbpf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_WAIT   = 80;
  localparam int RAND_ITEMS  = 210;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_data_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [OFFS_W-1:0]     out_match_offset;
  logic [BYTE_W-1:0]     out_window_byte;
  logic                  out_last_of_run;
  int                    mismatches;
  int                    pending_results;
  int                    results_checked;

  int                    burst_left;
  int                    bytes_sent;
  int                    settings_used;
  int                    stall_mode;
  int                    stall_left;

  gapped_byte_pair_finder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match_offset (out_match_offset),
    .out_window_byte  (out_window_byte),
    .out_last_of_run  (out_last_of_run)
  );

  gapped_byte_pair_finder_chk chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match_offset (out_match_offset),
    .out_window_byte  (out_window_byte),
    .out_last_of_run  (out_last_of_run),
    .mismatches       (mismatches),
    .pending_results  (pending_results),
    .results_checked  (results_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("gapped_byte_pair_finder_tb: FAIL");
    $finish;
  end

  // receiver stall pattern: quiet, light or heavy stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 100);
      out_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic settle();
    drain();
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] f,
                                                  input logic [BYTE_W-1:0] s);
    case ($urandom_range(0, 3))
      0: return f;
      1: return s;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [BYTE_W-1:0] seq [0:127];
    logic [BYTE_W-1:0] f;
    logic [BYTE_W-1:0] s;
    int                d;
    int                seq_len;
    int                plants;
    int                pos;
    int                phase;
    int                rand_sent;
    bit                keep_ring;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    out_stall = 1'b0;
    stall_mode = 0;
    stall_left = 0;
    burst_left = 0;
    bytes_sent = 0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero pair at distance one
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    settle();

    // unused index, then new pair values with the ring kept
    cfg_write(CFG_UNUSED, 8'hFF);
    cfg_write(CFG_FIRST_BYTE, 8'hFF);
    cfg_write(CFG_SECOND_BYTE, 8'h00);
    cfg_done();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    settle();

    // distance zero acts as one, upper data bits set
    cfg_write(CFG_FIRST_BYTE, 8'h80);
    cfg_write(CFG_SECOND_BYTE, 8'h01);
    cfg_write(CFG_DISTANCE, 8'hC0);
    cfg_done();
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h80);
    settle();

    cfg_write(CFG_FIRST_BYTE, 8'hA5);
    cfg_write(CFG_SECOND_BYTE, 8'h5A);
    cfg_write(CFG_DISTANCE, 8'd3);
    cfg_done();
    send_byte(8'hA5);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h5A);
    send_byte(8'h7F);
    send_byte(8'h5A);
    settle();

    // random phases with planted pairs
    rand_sent = 0;
    phase = 0;
    d = 3;
    while (rand_sent < RAND_ITEMS) begin
      keep_ring = (phase > 1) && ($urandom_range(0, 4) == 0);
      f = BYTE_W'($urandom_range(0, 255));
      s = ($urandom_range(0, 4) == 0) ? f : 8'($urandom_range(0, 255));
      cfg_write(CFG_FIRST_BYTE, f);
      cfg_write(CFG_SECOND_BYTE, s);
      if (!keep_ring) begin
        if (phase == 0) d = 63;
        else if (phase == 1) d = 0;
        else if ($urandom_range(0, 3) == 0) d = $urandom_range(9, 62);
        else d = $urandom_range(1, 8);
        cfg_write(CFG_DISTANCE, {2'($urandom_range(0, 3)), 6'(d)});
        if (d == 0) d = 1;
      end
      cfg_done();
      seq_len = d + $urandom_range(8, 24);
      for (int i = 0; i < seq_len; i++) seq[i] = pick_byte(f, s);
      plants = $urandom_range(1, 3);
      repeat (plants) begin
        pos = $urandom_range(d, seq_len - 1);
        seq[pos - d] = f;
        seq[pos] = s;
      end
      for (int i = 0; i < seq_len; i++) begin
        if (phase == 2 && i == seq_len / 2) drain();
        send_byte(seq[i]);
      end
      rand_sent += seq_len;
      phase++;
      settle();
    end

    $display("run covered %0d bytes under %0d register settings", bytes_sent, settings_used);
    $display("%0d window results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("gapped_byte_pair_finder_tb: PASS");
    end else begin
      $display("gapped_byte_pair_finder_tb: FAIL");
    end
    $finish;
  end

endmodule
